>>> rtl/core/circle_circle_intersection_top_defines.svh
// Assertion macros for the two-circle intersection core.
// Taken in by every RTL module that carries concurrent assertions.
`ifndef CIRCLE_CIRCLE_INTERSECTION_TOP_DEFINES_SVH
`define CIRCLE_CIRCLE_INTERSECTION_TOP_DEFINES_SVH
`ifndef SYNTH
`define CCI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define CCI_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define CCI_ASSERT(lbl, prop)
`define CCI_ASSERT_NR(lbl, prop)
`endif
`endif

>>> rtl/core/cci_pkg.sv
// Shared types and widths of the two-circle intersection core.
// No dependencies; used by the top level of the core.
`timescale 1ns / 1ps
package cci_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = CoordW - 1;

  typedef struct packed {
    logic signed [CoordW-1:0] center_a_x;
    logic signed [CoordW-1:0] center_a_y;
    logic [RadW-1:0]          radius_a;
    logic signed [CoordW-1:0] center_b_x;
    logic signed [CoordW-1:0] center_b_y;
    logic [RadW-1:0]          radius_b;
  } in_t;

  typedef struct packed {
    logic                     found;
    logic signed [CoordW-1:0] point1_x;
    logic signed [CoordW-1:0] point1_y;
    logic signed [CoordW-1:0] point2_x;
    logic signed [CoordW-1:0] point2_y;
  } out_t;

endpackage

>>> rtl/core/cci_isqrt.sv
// Pipelined integer square root: a row of cells, one root bit per cell.
// Depends on circle_circle_intersection_top_defines.svh for assertions.
`timescale 1ns / 1ps
`include "circle_circle_intersection_top_defines.svh"
module cci_isqrt #(
  parameter int unsigned RW = 66,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RW-1:0]    rad_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [RW/2-1:0]  root_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned QW = RW / 2;

  logic [QW-1:0] vld_q;
  logic [RW-1:0] rem_in [QW];
  logic [RW-1:0] rem_nx [QW];
  logic [RW-1:0] rem_q [QW];
  logic [QW-1:0] root_in [QW];
  logic [QW-1:0] root_nx [QW];
  logic [QW-1:0] root_q [QW];
  logic [SW-1:0] side_in [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_cell
    localparam int unsigned B = QW - 1 - i;
    logic [RW:0] trial;
    logic        take;

    if (i == 0) begin : g_head
      assign rem_in[i]  = rad_i;
      assign root_in[i] = '0;
      assign side_in[i] = side_i;
    end else begin : g_link
      assign rem_in[i]  = rem_q[i-1];
      assign root_in[i] = root_q[i-1];
      assign side_in[i] = side_q[i-1];
    end

    assign trial = ({1'b0, RW'(root_in[i])} << (B + 1)) | ((RW + 1)'(1) << (2 * B));
    assign take  = {1'b0, rem_in[i]} >= trial;
    assign rem_nx[i]  = take ? RW'({1'b0, rem_in[i]} - trial) : rem_in[i];
    assign root_nx[i] = take ? (root_in[i] | (QW'(1) << B)) : root_in[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i]  <= rem_nx[i];
        root_q[i] <= root_nx[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign root_o  = root_q[QW-1];
  assign side_o  = side_q[QW-1];

  // leftover radicand never exceeds twice the floored root
  `CCI_ASSERT_NR(a_sqrt_rem_bound, vld_q[QW-1] |-> ({1'b0, rem_q[QW-1]} <= ((RW + 1)'(root_q[QW-1]) << 1)))

endmodule

>>> rtl/core/cci_div.sv
// Pipelined restoring divider: a row of cells, one quotient bit per cell,
// shared divisor over LANES dividends. Standalone, no package use.
`timescale 1ns / 1ps
module cci_div #(
  parameter int unsigned NW    = 66,
  parameter int unsigned DW    = 34,
  parameter int unsigned QW    = 34,
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              dv_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              side_o
);

  logic [QW-1:0]             vld_q;
  logic [LANES-1:0][DW-1:0]  rem_in [QW];
  logic [LANES-1:0][DW-1:0]  rem_nx [QW];
  logic [LANES-1:0][DW-1:0]  rem_q [QW];
  logic [LANES-1:0][QW-1:0]  lo_in [QW];
  logic [LANES-1:0][QW-1:0]  lo_nx [QW];
  logic [LANES-1:0][QW-1:0]  lo_q [QW];
  logic [DW-1:0]             dv_in [QW];
  logic [DW-1:0]             dv_q [QW];
  logic [SW-1:0]             side_in [QW];
  logic [SW-1:0]             side_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_cell
    if (i == 0) begin : g_head
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign rem_in[i][l] = DW'(num_i[l] >> QW);
        assign lo_in[i][l]  = num_i[l][QW-1:0];
      end
      assign dv_in[i]   = dv_i;
      assign side_in[i] = side_i;
    end else begin : g_link
      assign rem_in[i]  = rem_q[i-1];
      assign lo_in[i]   = lo_q[i-1];
      assign dv_in[i]   = dv_q[i-1];
      assign side_in[i] = side_q[i-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] t;
      logic        take;
      assign t    = {rem_in[i][l], lo_in[i][l][QW-1]};
      assign take = t >= {1'b0, dv_in[i]};
      assign rem_nx[i][l] = take ? DW'(t - {1'b0, dv_in[i]}) : DW'(t);
      assign lo_nx[i][l]  = {lo_in[i][l][QW-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i]  <= rem_nx[i];
        lo_q[i]   <= lo_nx[i];
        dv_q[i]   <= dv_in[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = lo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

>>> rtl/core/circle_circle_intersection_top.sv
// Two-circle intersection core: top level with the full pipeline.
// Depends on cci_pkg, cci_isqrt, cci_div and the assertion macro header.
//
// Usage: one beat on the input channel carries two circles (centers
// signed Q16.16, radii unsigned Q15.16); one beat on the output channel
// carries found and the two intersection points, saturated to 32 bits.
// found=0 (separate, nested or coincident centers) gives all points zero.
// Throughput: one beat per cycle, sustained while out_ready_i stays high.
// Pipeline order, with W=32: five front
// stages, the distance root (W+1 cells), the offset divider (W+2 cells),
// two stages, the height root (W-1 cells), one multiply stage, the
// four-lane projection divider (W+2 cells), two back stages.
// Every stage advances together; when the output holds a beat the
// receiver has not taken, the whole pipeline and in_ready_o freeze until
// it is taken. Reset clears all valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`include "circle_circle_intersection_top_defines.svh"
module circle_circle_intersection_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cci_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cci_pkg::out_t out_data_o
);

  localparam int unsigned W    = cci_pkg::CoordW;
  localparam int unsigned RAW  = cci_pkg::RadW;
  localparam int unsigned AW   = W + 1;
  localparam int unsigned SQW  = 2 * W + 2;
  localparam int unsigned S2W  = 2 * W;
  localparam int unsigned R2W  = 2 * W - 2;
  localparam int unsigned DRW  = SQW / 2;
  localparam int unsigned AMW  = W + 2;
  localparam int unsigned HW   = R2W / 2;
  localparam int unsigned MW   = AMW + AW;
  localparam int unsigned QSW  = AMW + 1;
  localparam int unsigned PW   = W + 4;
  localparam int unsigned SUMW = PW + 1;

  typedef struct packed {
    logic [W-1:0]   ax, ay;
    logic [RAW-1:0] ra, rb;
    logic [AW-1:0]  adx, ady;
    logic           sdx, sdy;
    logic [W-1:0]   sum;
    logic [RAW-1:0] diff;
  } st1_t;

  typedef struct packed {
    logic [W-1:0]   ax, ay;
    logic [RAW-1:0] ra;
    logic [AW-1:0]  adx, ady;
    logic           sdx, sdy;
    logic [SQW-1:0] dx2, dy2;
    logic [S2W-1:0] sum2;
    logic [R2W-1:0] diff2, ra2, rb2;
  } st2_t;

  typedef struct packed {
    logic [W-1:0]   ax, ay;
    logic [RAW-1:0] ra;
    logic [AW-1:0]  adx, ady;
    logic           sdx, sdy;
    logic [SQW-1:0] d2;
    logic [S2W-1:0] sum2;
    logic [R2W-1:0] diff2, ra2, rb2;
  } st3_t;

  typedef struct packed {
    logic [W-1:0]   ax, ay;
    logic [RAW-1:0] ra;
    logic [AW-1:0]  adx, ady;
    logic           sdx, sdy;
    logic [SQW-1:0] d2, p;
    logic [R2W-1:0] ra2, rb2;
    logic           found;
  } st4_t;

  typedef struct packed {
    logic [W-1:0]   ax, ay;
    logic [RAW-1:0] ra;
    logic [R2W-1:0] ra2;
    logic [AW-1:0]  adx, ady;
    logic           sdx, sdy, found, aneg;
    logic [SQW-1:0] k;
  } side1_t;

  typedef struct packed {
    side1_t         sd;
    logic [SQW-1:0] d2;
  } st5_t;

  typedef struct packed {
    logic [W-1:0]   ax, ay;
    logic [RAW-1:0] ra;
    logic [R2W-1:0] ra2;
    logic [AW-1:0]  adx, ady;
    logic           sdx, sdy, found, aneg;
    logic [DRW-1:0] d;
  } side2_t;

  typedef struct packed {
    side2_t           sd;
    logic [AMW-1:0]   amag;
    logic [2*AMW-1:0] amag2;
    logic             lt;
  } st6_t;

  typedef struct packed {
    logic [W-1:0]   ax, ay;
    logic [AW-1:0]  adx, ady;
    logic           sdx, sdy, found, aneg;
    logic [DRW-1:0] d;
    logic [AMW-1:0] amag;
  } side3_t;

  typedef struct packed {
    side3_t         sd;
    logic [R2W-1:0] rad;
  } st7_t;

  typedef struct packed {
    logic [W-1:0] ax, ay;
    logic         sdx, sdy, found, aneg;
  } side4_t;

  typedef struct packed {
    side4_t              sd;
    logic [DRW-1:0]      d;
    logic [3:0][MW-1:0]  m;
  } st8_t;

  typedef struct packed {
    logic           found;
    logic [PW-1:0]  px, py;
    logic [QSW-1:0] ox, oy;
  } st9_t;

  function automatic logic [QSW-1:0] apply_sign_f(input logic [AMW-1:0] mag,
                                                  input logic neg);
    logic [QSW-1:0] m;
    m = {1'b0, mag};
    return neg ? QSW'(~m + QSW'(1)) : m;
  endfunction

  function automatic logic [W-1:0] sat_f(input logic [SUMW-1:0] v);
    logic [W-1:0] r;
    if (v[SUMW-1] && !(&v[SUMW-1:W-1])) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else if (!v[SUMW-1] && (|v[SUMW-1:W-1])) begin
      r = {1'b0, {(W-1){1'b1}}};
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, out_valid_q;
  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  st3_t s3_d, s3_q;
  st4_t s4_d, s4_q;
  st5_t s5_d, s5_q;
  st6_t s6_d, s6_q;
  st7_t s7_d, s7_q;
  st8_t s8_d, s8_q;
  st9_t s9_d, s9_q;
  cci_pkg::out_t out_d, out_q;

  logic [W:0] dx, dy;

  logic               sq1_valid;
  logic [DRW-1:0]     sq1_root;
  side1_t             sq1_sd;
  side2_t             dv1_side_in;
  logic               dv1_valid;
  logic [0:0][AMW-1:0] dv1_quo;
  side2_t             dv1_sd;
  logic               sq2_valid;
  logic [HW-1:0]      sq2_root;
  side3_t             sq2_sd;
  logic               dv4_valid;
  logic [3:0][AMW-1:0] dv4_quo;
  side4_t             dv4_sd;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // front: differences, magnitudes, radius sum and difference
  always_comb begin
    dx = {in_data_i.center_b_x[W-1], in_data_i.center_b_x}
       - {in_data_i.center_a_x[W-1], in_data_i.center_a_x};
    dy = {in_data_i.center_b_y[W-1], in_data_i.center_b_y}
       - {in_data_i.center_a_y[W-1], in_data_i.center_a_y};
    s1_d.ax   = in_data_i.center_a_x;
    s1_d.ay   = in_data_i.center_a_y;
    s1_d.ra   = in_data_i.radius_a;
    s1_d.rb   = in_data_i.radius_b;
    s1_d.sdx  = dx[W];
    s1_d.sdy  = dy[W];
    s1_d.adx  = dx[W] ? AW'(-dx) : dx;
    s1_d.ady  = dy[W] ? AW'(-dy) : dy;
    s1_d.sum  = {1'b0, in_data_i.radius_a} + {1'b0, in_data_i.radius_b};
    s1_d.diff = (in_data_i.radius_a > in_data_i.radius_b)
              ? in_data_i.radius_a - in_data_i.radius_b
              : in_data_i.radius_b - in_data_i.radius_a;
  end

  always_comb begin
    s2_d.ax    = s1_q.ax;
    s2_d.ay    = s1_q.ay;
    s2_d.ra    = s1_q.ra;
    s2_d.adx   = s1_q.adx;
    s2_d.ady   = s1_q.ady;
    s2_d.sdx   = s1_q.sdx;
    s2_d.sdy   = s1_q.sdy;
    s2_d.dx2   = SQW'(s1_q.adx) * SQW'(s1_q.adx);
    s2_d.dy2   = SQW'(s1_q.ady) * SQW'(s1_q.ady);
    s2_d.sum2  = S2W'(s1_q.sum) * S2W'(s1_q.sum);
    s2_d.diff2 = R2W'(s1_q.diff) * R2W'(s1_q.diff);
    s2_d.ra2   = R2W'(s1_q.ra) * R2W'(s1_q.ra);
    s2_d.rb2   = R2W'(s1_q.rb) * R2W'(s1_q.rb);
  end

  always_comb begin
    s3_d.ax    = s2_q.ax;
    s3_d.ay    = s2_q.ay;
    s3_d.ra    = s2_q.ra;
    s3_d.adx   = s2_q.adx;
    s3_d.ady   = s2_q.ady;
    s3_d.sdx   = s2_q.sdx;
    s3_d.sdy   = s2_q.sdy;
    s3_d.d2    = s2_q.dx2 + s2_q.dy2;
    s3_d.sum2  = s2_q.sum2;
    s3_d.diff2 = s2_q.diff2;
    s3_d.ra2   = s2_q.ra2;
    s3_d.rb2   = s2_q.rb2;
  end

  always_comb begin
    s4_d.ax    = s3_q.ax;
    s4_d.ay    = s3_q.ay;
    s4_d.ra    = s3_q.ra;
    s4_d.adx   = s3_q.adx;
    s4_d.ady   = s3_q.ady;
    s4_d.sdx   = s3_q.sdx;
    s4_d.sdy   = s3_q.sdy;
    s4_d.d2    = s3_q.d2;
    s4_d.ra2   = s3_q.ra2;
    s4_d.rb2   = s3_q.rb2;
    s4_d.found = (s3_q.d2 != '0) && (s3_q.d2 <= SQW'(s3_q.sum2))
              && (s3_q.d2 >= SQW'(s3_q.diff2));
    s4_d.p     = s3_q.d2 + SQW'(s3_q.ra2);
  end

  always_comb begin
    s5_d.sd.ax    = s4_q.ax;
    s5_d.sd.ay    = s4_q.ay;
    s5_d.sd.ra    = s4_q.ra;
    s5_d.sd.ra2   = s4_q.ra2;
    s5_d.sd.adx   = s4_q.adx;
    s5_d.sd.ady   = s4_q.ady;
    s5_d.sd.sdx   = s4_q.sdx;
    s5_d.sd.sdy   = s4_q.sdy;
    s5_d.sd.found = s4_q.found;
    s5_d.sd.aneg  = s4_q.p < SQW'(s4_q.rb2);
    s5_d.sd.k     = s5_d.sd.aneg ? SQW'(s4_q.rb2) - s4_q.p : s4_q.p - SQW'(s4_q.rb2);
    s5_d.d2       = s4_q.d2;
  end

  cci_isqrt #(
    .RW (SQW),
    .SW ($bits(side1_t))
  ) u_sqrt_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .rad_i   (s5_q.d2),
    .side_i  (s5_q.sd),
    .valid_o (sq1_valid),
    .root_o  (sq1_root),
    .side_o  (sq1_sd)
  );

  always_comb begin
    dv1_side_in.ax    = sq1_sd.ax;
    dv1_side_in.ay    = sq1_sd.ay;
    dv1_side_in.ra    = sq1_sd.ra;
    dv1_side_in.ra2   = sq1_sd.ra2;
    dv1_side_in.adx   = sq1_sd.adx;
    dv1_side_in.ady   = sq1_sd.ady;
    dv1_side_in.sdx   = sq1_sd.sdx;
    dv1_side_in.sdy   = sq1_sd.sdy;
    dv1_side_in.found = sq1_sd.found;
    dv1_side_in.aneg  = sq1_sd.aneg;
    dv1_side_in.d     = sq1_root;
  end

  // a = k / 2d
  cci_div #(
    .NW    (SQW),
    .DW    (DRW + 1),
    .QW    (AMW),
    .LANES (1),
    .SW    ($bits(side2_t))
  ) u_div_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq1_valid),
    .num_i   (sq1_sd.k),
    .dv_i    ({sq1_root, 1'b0}),
    .side_i  (dv1_side_in),
    .valid_o (dv1_valid),
    .quo_o   (dv1_quo),
    .side_o  (dv1_sd)
  );

  always_comb begin
    s6_d.sd    = dv1_sd;
    s6_d.amag  = dv1_quo[0];
    s6_d.amag2 = (2 * AMW)'(dv1_quo[0]) * (2 * AMW)'(dv1_quo[0]);
    s6_d.lt    = dv1_quo[0] < AMW'(dv1_sd.ra);
  end

  always_comb begin
    s7_d.sd.ax    = s6_q.sd.ax;
    s7_d.sd.ay    = s6_q.sd.ay;
    s7_d.sd.adx   = s6_q.sd.adx;
    s7_d.sd.ady   = s6_q.sd.ady;
    s7_d.sd.sdx   = s6_q.sd.sdx;
    s7_d.sd.sdy   = s6_q.sd.sdy;
    s7_d.sd.found = s6_q.sd.found;
    s7_d.sd.aneg  = s6_q.sd.aneg;
    s7_d.sd.d     = s6_q.sd.d;
    s7_d.sd.amag  = s6_q.amag;
    s7_d.rad      = s6_q.lt ? R2W'(s6_q.sd.ra2 - R2W'(s6_q.amag2)) : '0;
  end

  cci_isqrt #(
    .RW (R2W),
    .SW ($bits(side3_t))
  ) u_sqrt_height (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .rad_i   (s7_q.rad),
    .side_i  (s7_q.sd),
    .valid_o (sq2_valid),
    .root_o  (sq2_root),
    .side_o  (sq2_sd)
  );

  always_comb begin
    s8_d.sd.ax    = sq2_sd.ax;
    s8_d.sd.ay    = sq2_sd.ay;
    s8_d.sd.sdx   = sq2_sd.sdx;
    s8_d.sd.sdy   = sq2_sd.sdy;
    s8_d.sd.found = sq2_sd.found;
    s8_d.sd.aneg  = sq2_sd.aneg;
    s8_d.d        = sq2_sd.d;
    s8_d.m[0]     = MW'(sq2_sd.amag) * MW'(sq2_sd.adx);
    s8_d.m[1]     = MW'(sq2_sd.amag) * MW'(sq2_sd.ady);
    s8_d.m[2]     = MW'(sq2_root) * MW'(sq2_sd.ady);
    s8_d.m[3]     = MW'(sq2_root) * MW'(sq2_sd.adx);
  end

  // lanes: a*dx/d, a*dy/d, h*dy/d, h*dx/d
  cci_div #(
    .NW    (MW),
    .DW    (DRW),
    .QW    (AMW),
    .LANES (4),
    .SW    ($bits(side4_t))
  ) u_div_project (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .num_i   (s8_q.m),
    .dv_i    (s8_q.d),
    .side_i  (s8_q.sd),
    .valid_o (dv4_valid),
    .quo_o   (dv4_quo),
    .side_o  (dv4_sd)
  );

  always_comb begin
    logic [QSW-1:0] sax, say;
    sax = apply_sign_f(dv4_quo[0], dv4_sd.aneg ^ dv4_sd.sdx);
    say = apply_sign_f(dv4_quo[1], dv4_sd.aneg ^ dv4_sd.sdy);
    s9_d.found = dv4_sd.found;
    s9_d.px    = {{(PW-W){dv4_sd.ax[W-1]}}, dv4_sd.ax} + {{(PW-QSW){sax[QSW-1]}}, sax};
    s9_d.py    = {{(PW-W){dv4_sd.ay[W-1]}}, dv4_sd.ay} + {{(PW-QSW){say[QSW-1]}}, say};
    s9_d.ox    = apply_sign_f(dv4_quo[2], dv4_sd.sdy);
    s9_d.oy    = apply_sign_f(dv4_quo[3], dv4_sd.sdx);
  end

  always_comb begin
    logic [SUMW-1:0] px, py, ox, oy;
    px = {s9_q.px[PW-1], s9_q.px};
    py = {s9_q.py[PW-1], s9_q.py};
    ox = {{(SUMW-QSW){s9_q.ox[QSW-1]}}, s9_q.ox};
    oy = {{(SUMW-QSW){s9_q.oy[QSW-1]}}, s9_q.oy};
    out_d.found    = s9_q.found;
    out_d.point1_x = s9_q.found ? sat_f(px + ox) : '0;
    out_d.point1_y = s9_q.found ? sat_f(py - oy) : '0;
    out_d.point2_x = s9_q.found ? sat_f(px - ox) : '0;
    out_d.point2_y = s9_q.found ? sat_f(py + oy) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      v9_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= dv1_valid;
      v7_q        <= v6_q;
      v8_q        <= sq2_valid;
      v9_q        <= dv4_valid;
      out_valid_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      s5_q  <= s5_d;
      s6_q  <= s6_d;
      s7_q  <= s7_d;
      s8_q  <= s8_d;
      s9_q  <= s9_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CCI_ASSERT(a_miss_zero_points, out_valid_q && !out_q.found |-> (out_q.point1_x == '0) && (out_q.point1_y == '0) && (out_q.point2_x == '0) && (out_q.point2_y == '0))
  `CCI_ASSERT(a_stall_freezes_valids, !en |=> $stable({v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q}))
  `CCI_ASSERT(a_stall_freezes_last, v9_q && !en |=> $stable(s9_q))

endmodule
